// ===== rtl/bmct_pkg.sv =====
// Package for the BLE-MIDI clock tempo parser: payload structs, parse phases,
// command codes passed from the byte parser to the tempo tracker, and constants.
// Has no dependencies; every other file in rtl/ imports it.
package bmct_pkg;

    localparam int STAMP_W = 13;
    localparam int HIGH_W  = 6;
    localparam int LOW_W   = 7;
    localparam int COUNT_W = 7;
    localparam int PADDR_W = 3;

    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    localparam logic [COUNT_W-1:0] CPB_RESET = 7'd24;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_CLOCKS_PER_BEAT = 1'b0;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       first_of_packet;
    } t_in_item;

    typedef struct packed {
        logic               running;
        logic [STAMP_W-1:0] beat_period;
        logic               click;
        logic               packet_error;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_DROP,
        PH_FIRST_TS,
        PH_STATUS,
        PH_NEXT_TS
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_STOP,
        OP_CLOCK
    } t_op;

    // One classified byte, as handed from the parser to the tempo tracker.
    typedef struct packed {
        t_op                op;
        logic [STAMP_W-1:0] stamp;
        logic               err;
    } t_cmd;

    // Queue status seen by the parser and the tracker.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

// ===== rtl/bmct_front.sv =====
// Byte parser of the BLE-MIDI clock tempo parser: follows packet framing and
// the 13-bit timestamp, and turns every accepted byte into one command.
// Depends on bmct_pkg.
module bmct_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bmct_pkg::t_in_item i_in_item,
    input  bmct_pkg::t_q_status i_q_status,
    output logic              o_in_ready,
    output logic              o_push,
    output bmct_pkg::t_cmd    o_cmd
);
    import bmct_pkg::*;

    t_phase             r_phase, n_phase;
    logic [HIGH_W-1:0]  r_stamp_high, n_stamp_high;
    logic [LOW_W-1:0]   r_prev_low, n_prev_low;
    logic               r_prev_valid, n_prev_valid;
    logic [STAMP_W-1:0] r_msg_stamp, n_msg_stamp;

    logic              accept;
    logic              top_bit;
    logic [LOW_W-1:0]  low;
    logic [HIGH_W-1:0] wrap_high;
    t_op               status_op;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign top_bit    = i_in_item.packet_byte[7];
    assign low        = i_in_item.packet_byte[LOW_W-1:0];
    assign wrap_high  = (r_prev_valid && (low < r_prev_low)) ? r_stamp_high + 6'd1
                                                             : r_stamp_high;

    always_comb begin
        unique case (i_in_item.packet_byte)
            ST_START, ST_CONTINUE: status_op = OP_START;
            ST_STOP:               status_op = OP_STOP;
            ST_CLOCK:              status_op = OP_CLOCK;
            default:               status_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_stamp_high = r_stamp_high;
        n_prev_low   = r_prev_low;
        n_prev_valid = r_prev_valid;
        n_msg_stamp  = r_msg_stamp;
        o_cmd.op     = OP_NONE;
        o_cmd.stamp  = r_msg_stamp;
        o_cmd.err    = 1'b0;
        if (accept) begin
            if (i_in_item.first_of_packet) begin
                if (top_bit) begin
                    n_stamp_high = i_in_item.packet_byte[HIGH_W-1:0];
                    n_prev_valid = 1'b0;
                    n_phase      = PH_FIRST_TS;
                end else begin
                    o_cmd.err = 1'b1;
                    n_phase   = PH_DROP;
                end
            end else begin
                unique case (r_phase)
                    PH_FIRST_TS, PH_NEXT_TS: begin
                        if (top_bit) begin
                            n_stamp_high = wrap_high;
                            n_prev_low   = low;
                            n_prev_valid = 1'b1;
                            n_msg_stamp  = {wrap_high, low};
                            n_phase      = PH_STATUS;
                        end else if (r_phase == PH_FIRST_TS) begin
                            // No data bytes may follow the header directly.
                            o_cmd.err = 1'b1;
                            n_phase   = PH_DROP;
                        end
                    end
                    PH_STATUS: begin
                        if (top_bit) begin
                            o_cmd.op = status_op;
                            n_phase  = PH_NEXT_TS;
                        end else begin
                            o_cmd.err = 1'b1;
                            n_phase   = PH_DROP;
                        end
                    end
                    default: begin
                        n_phase = PH_DROP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DROP;
            r_stamp_high <= '0;
            r_prev_low   <= '0;
            r_prev_valid <= 1'b0;
            r_msg_stamp  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_stamp_high <= n_stamp_high;
            r_prev_low   <= n_prev_low;
            r_prev_valid <= n_prev_valid;
            r_msg_stamp  <= n_msg_stamp;
        end
    end

endmodule

// ===== rtl/bmct_queue.sv =====
// Two-entry command queue between the byte parser and the tempo tracker.
// Depends on bmct_pkg.
module bmct_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bmct_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output bmct_pkg::t_q_status o_status,
    output bmct_pkg::t_cmd      o_cmd
);
    import bmct_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.valid = (r_count != 2'd0);
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/bmct_back.sv =====
// Tempo tracker of the BLE-MIDI clock tempo parser: carries out start, stop
// and clock commands and holds the result in an output register.
// Depends on bmct_pkg.
module bmct_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bmct_pkg::t_q_status          i_q_status,
    input  bmct_pkg::t_cmd               i_cmd,
    input  logic [bmct_pkg::COUNT_W-1:0] i_clocks_per_beat,
    input  logic                         i_out_ready,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output bmct_pkg::t_out_item          o_out_item
);
    import bmct_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [STAMP_W-1:0] r_window, n_window;
    logic [STAMP_W-1:0] r_period, n_period;
    logic               r_running, n_running;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    assign o_pop       = i_q_status.valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_count     = r_count;
        n_window    = r_window;
        n_period    = r_period;
        n_running   = r_running;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_START: begin
                    n_count   = '0;
                    n_period  = '0;
                    n_running = 1'b1;
                end
                OP_STOP: begin
                    n_count   = '0;
                    n_running = 1'b0;
                end
                OP_CLOCK: begin
                    if (r_count == '0) begin
                        n_window = i_cmd.stamp;
                        n_count  = 7'd1;
                    end else if (r_count == i_clocks_per_beat) begin
                        n_period = i_cmd.stamp - r_window;
                        n_count  = '0;
                    end else begin
                        n_count = r_count + 7'd1;
                    end
                end
                default: begin
                end
            endcase
            n_out.running      = n_running;
            n_out.beat_period  = n_period;
            n_out.click        = (i_cmd.op == OP_START);
            n_out.packet_error = i_cmd.err;
            n_out_valid        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_window    <= '0;
            r_period    <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_window    <= n_window;
            r_period    <= n_period;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ble_midi_clock_tempo_parser.sv =====
// Top level of the BLE-MIDI clock tempo parser: configuration register,
// byte parser, command queue and tempo tracker.
// Depends on bmct_pkg, bmct_front, bmct_queue and bmct_back.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_in_item (t_in_item)
//   result    out        o_out_valid / i_out_ready     o_out_item (t_out_item)
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One byte is taken per cycle, back to back, while o_in_ready is high; each
// transfer yields exactly one result, written first into the queue and then
// by the tracker into the output register. Reset is synchronous and active
// low; there is no clearing pass. When the result side stalls, the two-entry
// queue absorbs up to two bytes before o_in_ready drops.
module ble_midi_clock_tempo_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bmct_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bmct_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmct_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bmct_pkg::*;

    logic [COUNT_W-1:0] r_clocks_per_beat;
    logic               reg_sel;
    logic               push;
    logic               pop;
    t_cmd               front_cmd;
    t_cmd               queue_cmd;
    t_q_status          q_status;

    // The register sits at byte address zero; the address bit above the word
    // offset selects the register, and writes to other words are dropped.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_CLOCKS_PER_BEAT);
    assign prdata  = reg_sel ? {25'd0, r_clocks_per_beat} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clocks_per_beat <= CPB_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_clocks_per_beat <= pwdata[COUNT_W-1:0];
        end
    end

    // Framing and timestamp tracking; every accepted byte becomes a command.
    bmct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    bmct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_status (q_status),
        .o_cmd    (queue_cmd)
    );

    // Clock counting and period measurement, plus the result register.
    bmct_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_status        (q_status),
        .i_cmd             (queue_cmd),
        .i_clocks_per_beat (r_clocks_per_beat),
        .i_out_ready       (i_out_ready),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .o_out_item        (o_out_item)
    );

endmodule
